/* design/fpn3_pkg.sv */
// ---------------------------------------------------------------------------
// fpn3_pkg: shared types, constants and helpers for the fractal noise block
// Datapath command codes, controller/datapath handshake structs, the lattice
// permutation and the gradient index reduction.
// ---------------------------------------------------------------------------
`default_nettype none

package fpn3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int DIV_W     = 32;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE_X,
    OP_SCALE_Y,
    OP_FADE1,
    OP_FADE2,
    OP_FADE3,
    OP_FADE4,
    OP_HASH1,
    OP_HASH2,
    OP_HASH3,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_ACC,
    OP_OCT_END,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [1:0]  axis;
    logic [2:0]  corner;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  // Reduce a hash to a gradient index: h/12 via reciprocal 171/2048,
  // exact for every 8-bit h.
  function automatic logic [3:0] grad_index(input logic [7:0] h);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    p = 16'(h) * 16'd171;
    q = p[15:11];
    r = h - 8'(8'(q) * 8'd12);
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

/* design/fpn3_ctrl.sv */
// ---------------------------------------------------------------------------
// fpn3_ctrl: sequencer for the fractal noise datapath
// Steps one item through scaling, per-octave fades and corner blends, the
// normalising division and the output hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module fpn3_ctrl #(
  parameter int OCT_W       = 3
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire  [OCT_W-1:0]        oct_eff,
  input  fpn3_pkg::dp_status_t    status,
  output fpn3_pkg::dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ACC,
    ST_OCT_END,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  localparam logic [1:0] AXIS_LAST   = 2'd2;
  localparam logic [2:0] CORNER_LAST = 3'd7;
  localparam int         DCNT_W      = $clog2(fpn3_pkg::DIV_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(fpn3_pkg::DIV_W - 1);

  state_t            state;
  logic [1:0]        axis;
  logic [2:0]        corner;
  logic [OCT_W-1:0]  oct_idx;
  logic [DCNT_W-1:0] dcnt;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd.axis   = axis;
    cmd.corner = corner;
    unique case (state)
      ST_IDLE:     cmd.op = in_valid ? fpn3_pkg::OP_LOAD : fpn3_pkg::OP_NONE;
      ST_SCALE_X:  cmd.op = fpn3_pkg::OP_SCALE_X;
      ST_SCALE_Y:  cmd.op = fpn3_pkg::OP_SCALE_Y;
      ST_F1:       cmd.op = fpn3_pkg::OP_FADE1;
      ST_F2:       cmd.op = fpn3_pkg::OP_FADE2;
      ST_F3:       cmd.op = fpn3_pkg::OP_FADE3;
      ST_F4:       cmd.op = fpn3_pkg::OP_FADE4;
      ST_H1:       cmd.op = fpn3_pkg::OP_HASH1;
      ST_H2:       cmd.op = fpn3_pkg::OP_HASH2;
      ST_H3:       cmd.op = fpn3_pkg::OP_HASH3;
      ST_M1:       cmd.op = fpn3_pkg::OP_MUL1;
      ST_M2:       cmd.op = fpn3_pkg::OP_MUL2;
      ST_M3:       cmd.op = fpn3_pkg::OP_MUL3;
      ST_ACC:      cmd.op = fpn3_pkg::OP_ACC;
      ST_OCT_END:  cmd.op = fpn3_pkg::OP_OCT_END;
      ST_DIV_INIT: cmd.op = fpn3_pkg::OP_DIV_INIT;
      ST_DIV:      cmd.op = fpn3_pkg::OP_DIV_STEP;
      ST_FINISH:   cmd.op = status.out_free ? fpn3_pkg::OP_OUT : fpn3_pkg::OP_NONE;
      default:     cmd.op = fpn3_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      axis    <= '0;
      corner  <= '0;
      oct_idx <= '0;
      dcnt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE:    if (in_valid) state <= ST_SCALE_X;
        ST_SCALE_X: state <= ST_SCALE_Y;
        ST_SCALE_Y: begin
          oct_idx <= '0;
          axis    <= '0;
          state   <= ST_F1;
        end
        ST_F1: state <= ST_F2;
        ST_F2: state <= ST_F3;
        ST_F3: state <= ST_F4;
        ST_F4: begin
          if (axis == AXIS_LAST) begin
            axis   <= '0;
            corner <= '0;
            state  <= ST_H1;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_F1;
          end
        end
        ST_H1: state <= ST_H2;
        ST_H2: state <= ST_H3;
        ST_H3: state <= ST_M1;
        ST_M1: state <= ST_M2;
        ST_M2: state <= ST_M3;
        ST_M3: state <= ST_ACC;
        ST_ACC: begin
          if (corner == CORNER_LAST) begin
            state <= ST_OCT_END;
          end else begin
            corner <= corner + 3'd1;
            state  <= ST_H1;
          end
        end
        ST_OCT_END: begin
          if (oct_idx == OCT_W'(oct_eff - OCT_W'(1))) begin
            state <= ST_DIV_INIT;
          end else begin
            oct_idx <= oct_idx + OCT_W'(1);
            state   <= ST_F1;
          end
        end
        ST_DIV_INIT: begin
          dcnt  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (dcnt == DIV_LAST) state <= ST_FINISH;
          else dcnt <= dcnt + DCNT_W'(1);
        end
        ST_FINISH: if (status.out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/fpn3_dp.sv */
// ---------------------------------------------------------------------------
// fpn3_dp: fixed-point datapath for the fractal noise block
// One shared signed multiplier, the permutation lookup, a corner dot product,
// the octave accumulator, a bit-serial divider and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module fpn3_dp (
  input  wire                     clk,
  input  wire                     rst,
  input  fpn3_pkg::dp_cmd_t       cmd,
  output fpn3_pkg::dp_status_t    status,
  input  wire  signed [23:0]      pos_x,
  input  wire  signed [23:0]      pos_y,
  input  wire  [15:0]             scale,
  input  wire  [14:0]             time_speed,
  input  wire  [7:0]              divisor,
  output logic [15:0]             noise_value,
  output logic                    out_valid,
  input  wire                     out_stall
);

  localparam int DW = fpn3_pkg::DIV_W;

  logic signed [23:0] pos_x_q, pos_y_q;
  logic [23:0]        time_accum;
  logic [23:0]        px, py, pz;
  logic signed [24:0] ta, tb;
  logic signed [17:0] fu, fv, fw;
  logic [7:0]         hr;
  logic [3:0]         g;
  logic signed [24:0] sum;
  logic signed [31:0] total;
  logic               neg;
  logic [DW-1:0]      dq;
  logic [7:0]         rem;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic signed [24:0] prod16;
  logic [15:0]        fsel;
  logic [18:0]        six_f;
  logic               bx, by, bz;
  logic signed [17:0] wx, wy, wz;
  logic signed [17:0] dx, dy, dz;
  logic signed [18:0] t1, t2, dot;
  logic [7:0]         hidx, perm_out;
  logic signed [24:0] n_oct;
  logic [8:0]         rs;
  logic               qbit;

  assign status.out_free = !out_valid || !out_stall;

  assign bx = cmd.corner[2];
  assign by = cmd.corner[1];
  assign bz = cmd.corner[0];

  always_comb begin
    case (cmd.axis)
      2'd0:    fsel = px[15:0];
      2'd1:    fsel = py[15:0];
      default: fsel = pz[15:0];
    endcase
  end

  assign six_f = ({3'b0, fsel} << 2) + ({3'b0, fsel} << 1);

  assign wx = bx ? fu : 18'sd65536 - fu;
  assign wy = by ? fv : 18'sd65536 - fv;
  assign wz = bz ? fw : 18'sd65536 - fw;

  assign dx = $signed({2'b0, px[15:0]}) - (bx ? 18'sd65536 : 18'sd0);
  assign dy = $signed({2'b0, py[15:0]}) - (by ? 18'sd65536 : 18'sd0);
  assign dz = $signed({2'b0, pz[15:0]}) - (bz ? 18'sd65536 : 18'sd0);

  // Gradients pair x,y then x,z then y,z; bit 0 flips the first term, bit 1 the second.
  always_comb begin
    t1 = (g < 4'd8) ? {dx[17], dx} : {dy[17], dy};
    t2 = (g < 4'd4) ? {dy[17], dy} : {dz[17], dz};
    if (g[0]) t1 = -t1;
    if (g[1]) t2 = -t2;
    dot = t1 + t2;
  end

  always_comb begin
    case (cmd.op)
      fpn3_pkg::OP_SCALE_X: begin
        mul_a = {pos_x_q[23], pos_x_q};
        mul_b = {9'b0, scale};
      end
      fpn3_pkg::OP_SCALE_Y: begin
        mul_a = {pos_y_q[23], pos_y_q};
        mul_b = {9'b0, scale};
      end
      fpn3_pkg::OP_FADE1: begin
        mul_a = {9'b0, fsel};
        mul_b = {9'b0, fsel};
      end
      fpn3_pkg::OP_FADE2: begin
        mul_a = ta;
        mul_b = {9'b0, fsel};
      end
      fpn3_pkg::OP_FADE3: begin
        mul_a = {9'b0, fsel};
        mul_b = $signed({6'b0, six_f}) - 25'sd983040;
      end
      fpn3_pkg::OP_FADE4: begin
        mul_a = ta;
        mul_b = tb + 25'sd655360;
      end
      fpn3_pkg::OP_MUL1: begin
        mul_a = {{6{dot[18]}}, dot};
        mul_b = {{7{wx[17]}}, wx};
      end
      fpn3_pkg::OP_MUL2: begin
        mul_a = ta;
        mul_b = {{7{wy[17]}}, wy};
      end
      fpn3_pkg::OP_MUL3: begin
        mul_a = ta;
        mul_b = {{7{wz[17]}}, wz};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod16 = prod[40:16];

  always_comb begin
    case (cmd.op)
      fpn3_pkg::OP_HASH1: hidx = px[23:16] + {7'b0, bx};
      fpn3_pkg::OP_HASH2: hidx = hr + py[23:16] + {7'b0, by};
      default:            hidx = hr + pz[23:16] + {7'b0, bz};
    endcase
  end

  assign perm_out = fpn3_pkg::PERM[hidx];

  assign n_oct = (sum + 25'sd65536) >>> 1;

  assign rs   = {rem, dq[DW-1]};
  assign qbit = (rs >= {1'b0, divisor});

  // Control state: time accumulator and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_accum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.op == fpn3_pkg::OP_LOAD) time_accum <= time_accum + {9'b0, time_speed};
      if (cmd.op == fpn3_pkg::OP_OUT) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fpn3_pkg::OP_LOAD: begin
        pos_x_q <= pos_x;
        pos_y_q <= pos_y;
      end
      fpn3_pkg::OP_SCALE_X: px <= prod[35:12];
      fpn3_pkg::OP_SCALE_Y: begin
        py    <= prod[35:12];
        pz    <= time_accum;
        total <= '0;
        sum   <= '0;
      end
      fpn3_pkg::OP_FADE1, fpn3_pkg::OP_FADE2: ta <= prod16;
      fpn3_pkg::OP_FADE3: tb <= prod16;
      fpn3_pkg::OP_FADE4: begin
        case (cmd.axis)
          2'd0:    fu <= prod16[17:0];
          2'd1:    fv <= prod16[17:0];
          default: fw <= prod16[17:0];
        endcase
      end
      fpn3_pkg::OP_HASH1, fpn3_pkg::OP_HASH2: hr <= perm_out;
      fpn3_pkg::OP_HASH3: g <= fpn3_pkg::grad_index(perm_out);
      fpn3_pkg::OP_MUL1, fpn3_pkg::OP_MUL2, fpn3_pkg::OP_MUL3: ta <= prod16;
      fpn3_pkg::OP_ACC: sum <= sum + ta;
      fpn3_pkg::OP_OCT_END: begin
        // Horner form of the doubling weights; advance to the next octave.
        total <= (total <<< 1) + {{7{n_oct[24]}}, n_oct};
        sum   <= '0;
        px    <= px << 1;
        py    <= py << 1;
        pz    <= pz << 1;
      end
      fpn3_pkg::OP_DIV_INIT: begin
        neg <= total[31];
        dq  <= total;
        rem <= '0;
      end
      fpn3_pkg::OP_DIV_STEP: begin
        rem <= qbit ? 8'(rs - {1'b0, divisor}) : rs[7:0];
        dq  <= {dq[DW-2:0], qbit};
      end
      fpn3_pkg::OP_OUT: begin
        if (neg) noise_value <= '0;
        else if (|dq[DW-1:16]) noise_value <= 16'hFFFF;
        else noise_value <= dq[15:0];
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/fractal_perlin_noise_3d.sv */
// ---------------------------------------------------------------------------
// fractal_perlin_noise_3d: fractal 3D gradient noise over a position stream
// Input channel: pos_x/pos_y (signed Q12.12) with in_valid/in_stall; a
// transfer happens when in_valid is high and in_stall low. Each item also
// advances the internal Q8.16 time coordinate by time_speed.
// Output channel: noise_value (Q0.16) with out_valid/out_stall, one result
// per item, in order.
// Sequencing: one item at a time on a single shared multiplier. With K octaves
// an item runs through 2 scaling steps, per octave 12 fade steps, 8 corners
// of 7 steps and one accumulate, then a 32-step bit-serial divide by 2^K-1
// and the output load. out_valid is registered from the output load.
// A finished result sits in the output register; the next item is taken
// while it waits. If the receiver stalls, the following result holds in the
// datapath until the output register frees.
// Reset (synchronous) clears the time coordinate, empties the output and
// restores scale 6554, time_speed 655, octave_count 1.
// Configuration: APB registers scale (0x0), time_speed (0x4),
// octave_count (0x8); write only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module fractal_perlin_noise_3d #(
  parameter int MAX_OCTAVES = 5
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [3:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  signed [23:0] pos_x,
  input  wire  signed [23:0] pos_y,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [15:0]       noise_value
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam logic [3:0] MAX_OCT = 4'(MAX_OCTAVES);

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_SPEED  = 2'd1;
  localparam logic [1:0] REG_OCTAVE = 2'd2;

  logic [15:0] scale;
  logic [14:0] time_speed;
  logic [2:0]  octave_count;
  logic        wr_en;
  logic [3:0]  oct_cnt4, oct_eff4;
  logic [OCT_W-1:0] oct_eff;
  logic [7:0]  divisor;

  fpn3_pkg::dp_cmd_t    cmd;
  fpn3_pkg::dp_status_t status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= 16'd6554;
      time_speed   <= 15'd655;
      octave_count <= 3'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SCALE:  scale        <= pwdata[15:0];
        REG_SPEED:  time_speed   <= pwdata[14:0];
        REG_OCTAVE: octave_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE:  prdata = {16'b0, scale};
      REG_SPEED:  prdata = {17'b0, time_speed};
      REG_OCTAVE: prdata = {29'b0, octave_count};
      default:    prdata = '0;
    endcase
  end

  // Zero counts as one octave; clamp anything above the build limit.
  always_comb begin
    oct_cnt4 = {1'b0, octave_count};
    if (oct_cnt4 == 4'd0) oct_eff4 = 4'd1;
    else if (oct_cnt4 > MAX_OCT) oct_eff4 = MAX_OCT;
    else oct_eff4 = oct_cnt4;
  end

  assign oct_eff = OCT_W'(oct_eff4);
  assign divisor = 8'((9'd1 << oct_eff4) - 9'd1);

  fpn3_ctrl #(
    .OCT_W       (OCT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .oct_eff  (oct_eff),
    .status   (status),
    .cmd      (cmd)
  );

  fpn3_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .scale       (scale),
    .time_speed  (time_speed),
    .divisor     (divisor),
    .noise_value (noise_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule

`default_nettype wire
